// File: hdl/tmprof_pkg.sv
// Package for the trapezoidal motion profiler: register indexes, reset values,
// controller states and the command and status structs between controller and datapath.
// No dependencies.
package tmprof_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned PosW     = 48;
  localparam int unsigned VelW     = 32;
  localparam int unsigned TickW    = 16;

  localparam logic [CfgIdxW-1:0] RegAccel = 4'd0;
  localparam logic [CfgIdxW-1:0] RegDecel = 4'd1;
  localparam logic [CfgIdxW-1:0] RegLimit = 4'd2;
  localparam logic [CfgIdxW-1:0] RegTick  = 4'd3;

  localparam logic [31:0] AccelReset = 32'd655360;
  localparam logic [31:0] DecelReset = 32'd655360;
  localparam logic [31:0] LimitReset = 32'd6553600;
  localparam logic [15:0] TickReset  = 16'd655;

  localparam logic [PosW-1:0] PosMax = 48'h7FFF_FFFF_FFFF;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_VV,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_SUM,
    OP_CMP,
    OP_MUL_RATE,
    OP_VEL,
    OP_MUL_POS,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VV,
    ST_LO,
    ST_HI,
    ST_SUM,
    ST_CMP,
    ST_RATE,
    ST_VEL,
    ST_PMUL,
    ST_EMIT
  } ctl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

// File: hdl/tmprof_dp.sv
// Datapath of the motion profiler: configuration registers, state, one shared
// 32x32 multiplier, distance compare, velocity and position update, output register.
// Depends on tmprof_pkg.
module tmprof_dp import tmprof_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  input  logic signed [PosW-1:0]     goal_position_i,
  input  logic                       out_ready_i,
  input  dp_cmd_t                    cmd_i,
  output dp_status_t                 status_o,
  output logic                       out_valid_o,
  output logic signed [PosW-1:0]     new_position_o,
  output logic [VelW-1:0]            new_velocity_o
);

  logic [31:0]        accel_q, decel_q, limit_q;
  logic [TickW-1:0]   tick_q;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [VelW-1:0]    vel_q, vel_d;
  logic [PosW:0]      dist_q;
  logic [63:0]        prod_q, prod_d;
  logic [63:0]        vv_q;
  logic [63:0]        lo_q;
  logic [80:0]        acc_q;
  logic               far_q;
  logic               out_valid_q;
  logic [PosW-1:0]    out_pos_q;
  logic [VelW-1:0]    out_vel_q;

  logic [31:0]        mul_a, mul_b;
  logic [31:0]        step;
  logic [32:0]        vsum;
  logic [PosW:0]      psum;
  logic               dist_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= AccelReset;
      decel_q <= DecelReset;
      limit_q <= LimitReset;
      tick_q  <= TickReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegAccel: accel_q <= cfg_data_i;
        RegDecel: decel_q <= cfg_data_i;
        RegLimit: limit_q <= cfg_data_i;
        RegTick:  tick_q  <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_a = vel_q;
    mul_b = vel_q;
    case (cmd_i.op)
      OP_MUL_LO: begin
        mul_a = decel_q;
        mul_b = dist_q[31:0];
      end
      OP_MUL_HI: begin
        mul_a = decel_q;
        mul_b = {16'd0, dist_q[PosW-1:32]};
      end
      OP_MUL_RATE: begin
        mul_a = far_q ? accel_q : decel_q;
        mul_b = {16'd0, tick_q};
      end
      OP_MUL_POS: begin
        mul_a = vel_q;
        mul_b = {16'd0, tick_q};
      end
      default: ;
    endcase
    prod_d = 64'(mul_a) * 64'(mul_b);
  end

  assign step     = prod_q[47:16];
  assign dist_pos = !dist_q[PosW] && (|dist_q[PosW-1:0]);

  always_comb begin
    vsum = {1'b0, vel_q} + {1'b0, step};
    if (far_q) begin
      vel_d = (vsum > {1'b0, limit_q}) ? limit_q : vsum[31:0];
    end else begin
      vel_d = (vel_q > step) ? vel_q - step : '0;
    end
    psum = {pos_q[PosW-1], pos_q} + {17'd0, step};
    pos_d = (psum[PosW:PosW-1] == 2'b01) ? PosMax : psum[PosW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      vel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_VEL) begin
        vel_q <= vel_d;
      end
      if (cmd_i.op == OP_EMIT) begin
        pos_q       <= pos_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op) inside
      OP_LOAD: dist_q <= {goal_position_i[PosW-1], goal_position_i} - {pos_q[PosW-1], pos_q};
      OP_MUL_VV, OP_MUL_RATE, OP_MUL_POS: prod_q <= prod_d;
      OP_MUL_LO: begin
        vv_q   <= prod_q;
        prod_q <= prod_d;
      end
      OP_MUL_HI: begin
        lo_q   <= prod_q;
        prod_q <= prod_d;
      end
      OP_SUM: acc_q <= {17'd0, lo_q} + {prod_q[48:0], 32'd0};
      OP_CMP: far_q <= dist_pos && ({acc_q, 1'b0} > {18'd0, vv_q});
      OP_EMIT: begin
        out_pos_q <= pos_d;
        out_vel_q <= vel_q;
      end
      default: ;
    endcase
  end

  assign status_o.out_busy = out_valid_q;
  assign out_valid_o       = out_valid_q;
  assign new_position_o    = out_pos_q;
  assign new_velocity_o    = out_vel_q;

endmodule

// File: hdl/tmprof_ctrl.sv
// Controller of the motion profiler: sequences one tick through the datapath, one
// command per cycle, and stalls in its last step while the output is full.
// Depends on tmprof_pkg.
module tmprof_ctrl import tmprof_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_VV;
        end
      end
      ST_VV: begin
        cmd_o.op = OP_MUL_VV;
        state_d  = ST_LO;
      end
      ST_LO: begin
        cmd_o.op = OP_MUL_LO;
        state_d  = ST_HI;
      end
      ST_HI: begin
        cmd_o.op = OP_MUL_HI;
        state_d  = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.op = OP_SUM;
        state_d  = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.op = OP_CMP;
        state_d  = ST_RATE;
      end
      ST_RATE: begin
        cmd_o.op = OP_MUL_RATE;
        state_d  = ST_VEL;
      end
      ST_VEL: begin
        cmd_o.op = OP_VEL;
        state_d  = ST_PMUL;
      end
      ST_PMUL: begin
        cmd_o.op = OP_MUL_POS;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status_i.out_busy || out_ready_i) begin
          cmd_o.op = OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/trapezoidal_motion_profiler.sv
// Top level of the trapezoidal motion profiler: controller plus datapath.
// Depends on tmprof_pkg, tmprof_ctrl and tmprof_dp.
//
//   channel | signals                                   | transfer when
//   --------+-------------------------------------------+------------------------
//   input   | in_valid_i, in_ready_o, goal_position_i   | in_valid_i & in_ready_o
//   output  | out_valid_o, out_ready_i, new_position_o, | out_valid_o & out_ready_i
//           | new_velocity_o                            |
//   config  | cfg_we_i, cfg_idx_i, cfg_data_i           | cfg_we_i
//
// A tick runs through the accept step and nine sequencer steps, five of which share
// the single 32x32 multiplier. The result is registered in the EMIT step, and the
// next input is taken in the cycle after that.
// The output register holds a result while the next tick is worked on; a tick
// finished before the previous result is taken waits in its last step.
// Reset clears position and velocity and loads the default registers.
module trapezoidal_motion_profiler import tmprof_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [PosW-1:0] goal_position_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [PosW-1:0] new_position_o,
  output logic [VelW-1:0]        new_velocity_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  tmprof_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tmprof_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .goal_position_i (goal_position_i),
    .out_ready_i     (out_ready_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .new_position_o  (new_position_o),
    .new_velocity_o  (new_velocity_o)
  );

endmodule
